### rtl/wsa_pkg.sv
// Shared types, constants and fixed-point helpers for the waterline segment area block.
package wsa_pkg;

  localparam int unsigned PreLast  = 8;
  localparam int unsigned PassLast = 30;
  localparam int unsigned CubeLast = 3;

  localparam logic signed [31:0] OneQ   = 32'sd65536;
  localparam logic signed [31:0] HalfQ  = 32'sd32768;
  localparam logic signed [31:0] ThirdQ = 32'sd21845;
  localparam logic signed [31:0] TwoQ   = 32'sd131072;

  typedef enum logic [1:0] {
    CFG_SIN  = 2'd0,
    CFG_COS  = 2'd1,
    CFG_TANK = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_MUL = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } alu_op_e;

  typedef enum logic [4:0] {
    S_T, S_DWL, S_A, S_HB, S_C, S_HD, S_YO, S_ZO, S_SIN, S_COS,
    S_HALF, S_THIRD, S_TWO, S_M1, S_M2, S_DY, S_DZ, S_WID, S_ACC,
    S_K1, S_K2, S_K3, S_Y, S_Z
  } src_e;

  typedef enum logic [3:0] {
    D_NONE, D_M1, D_M2, D_DY, D_DZ, D_WID, D_ACC, D_K1, D_K2, D_K3,
    D_Y, D_Z, D_S
  } dst_e;

  typedef struct packed {
    alu_op_e op;
    src_e    src_a;
    src_e    src_b;
    dst_e    dst;
  } uop_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PRE  = 7'b0000010,
    ST_PASS = 7'b0000100,
    ST_CUBE = 7'b0001000,
    ST_FIN1 = 7'b0010000,
    ST_FIN2 = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  function automatic uop_t ucode(logic pre, logic [4:0] step);
    uop_t u;
    u = '{OP_NOP, S_T, S_T, D_NONE};
    if (pre) begin
      case (step)
        5'd0: u = '{OP_MUL, S_A, S_C, D_M1};
        5'd1: u = '{OP_MUL, S_M1, S_HALF, D_K1};
        5'd2: u = '{OP_MUL, S_A, S_HD, D_M1};
        5'd3: u = '{OP_MUL, S_HB, S_C, D_M2};
        5'd4: u = '{OP_MUL, S_M2, S_TWO, D_M2};
        5'd5: u = '{OP_ADD, S_M1, S_M2, D_M1};
        5'd6: u = '{OP_MUL, S_THIRD, S_M1, D_K2};
        5'd7: u = '{OP_MUL, S_HB, S_HD, D_M1};
        5'd8: u = '{OP_MUL, S_M1, S_HALF, D_K3};
        default: u = '{OP_NOP, S_T, S_T, D_NONE};
      endcase
    end else begin
      case (step)
        5'd0:  u = '{OP_MUL, S_T, S_HB, D_M1};
        5'd1:  u = '{OP_ADD, S_A, S_M1, D_M1};
        5'd2:  u = '{OP_MUL, S_T, S_M1, D_DY};
        5'd3:  u = '{OP_MUL, S_T, S_HD, D_M1};
        5'd4:  u = '{OP_ADD, S_C, S_M1, D_M1};
        5'd5:  u = '{OP_MUL, S_T, S_M1, D_DZ};
        5'd6:  u = '{OP_MUL, S_SIN, S_DZ, D_M1};
        5'd7:  u = '{OP_MUL, S_COS, S_DY, D_M2};
        5'd8:  u = '{OP_ADD, S_M1, S_M2, D_WID};
        5'd9:  u = '{OP_MUL, S_COS, S_DZ, D_M1};
        5'd10: u = '{OP_MUL, S_SIN, S_DY, D_M2};
        5'd11: u = '{OP_SUB, S_M1, S_M2, D_M1};
        5'd12: u = '{OP_MUL, S_HALF, S_M1, D_M1};
        5'd13: u = '{OP_SUB, S_DWL, S_M1, D_M1};
        5'd14: u = '{OP_MUL, S_M1, S_WID, D_ACC};
        5'd15: u = '{OP_MUL, S_HALF, S_DY, D_M1};
        5'd16: u = '{OP_MUL, S_M1, S_DZ, D_M1};
        5'd17: u = '{OP_ADD, S_ACC, S_M1, D_ACC};
        5'd18: u = '{OP_MUL, S_T, S_K3, D_M1};
        5'd19: u = '{OP_ADD, S_K2, S_M1, D_M1};
        5'd20: u = '{OP_MUL, S_T, S_M1, D_M1};
        5'd21: u = '{OP_ADD, S_K1, S_M1, D_M1};
        5'd22: u = '{OP_MUL, S_T, S_T, D_M2};
        5'd23: u = '{OP_MUL, S_M2, S_M1, D_M1};
        5'd24: u = '{OP_SUB, S_ACC, S_M1, D_ACC};
        5'd25: u = '{OP_ADD, S_YO, S_DY, D_Y};
        5'd26: u = '{OP_SUB, S_ZO, S_DZ, D_Z};
        5'd27: u = '{OP_MUL, S_COS, S_Y, D_M1};
        5'd28: u = '{OP_MUL, S_SIN, S_Z, D_M2};
        5'd29: u = '{OP_SUB, S_M1, S_M2, D_S};
        default: u = '{OP_NOP, S_T, S_T, D_NONE};
      endcase
    end
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sh7fffffff) r = 32'sh7fffffff;
    else if (x < -66'sh80000000) r = -32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qas(logic signed [31:0] a, logic signed [31:0] b,
                                             logic sub);
    logic signed [32:0] s;
    s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
    return sat32(66'(s));
  endfunction

  function automatic logic signed [63:0] sas64(logic signed [63:0] a, logic signed [63:0] b,
                                               logic sub);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

endpackage

### rtl/wsa_in_if.sv
// Input channel carrying one hull-section curve segment word.
interface wsa_in_if;
  import wsa_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] outer_param;
  logic signed [31:0] inner_param;
  logic signed [31:0] depth_over_inner;
  logic signed [31:0] coef_y_lin;
  logic signed [31:0] coef_y_sq;
  logic signed [31:0] coef_z_lin;
  logic signed [31:0] coef_z_sq;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic               first_segment;

  modport source (output valid, outer_param, inner_param, depth_over_inner, coef_y_lin,
                  coef_y_sq, coef_z_lin, coef_z_sq, origin_y, origin_z, first_segment,
                  input ready);
  modport sink (input valid, outer_param, inner_param, depth_over_inner, coef_y_lin,
                coef_y_sq, coef_z_lin, coef_z_sq, origin_y, origin_z, first_segment,
                output ready);
endinterface

### rtl/wsa_out_if.sv
// Output channel carrying one segment area result word.
interface wsa_out_if;
  import wsa_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] segment_area;
  logic signed [31:0] wetted_width;
  logic signed [63:0] wetted_cube;
  logic               crossing_found;
  logic signed [31:0] crossing_y;
  logic signed [31:0] crossing_z;

  modport source (output valid, segment_area, wetted_width, wetted_cube, crossing_found,
                  crossing_y, crossing_z, input ready);
  modport sink (input valid, segment_area, wetted_width, wetted_cube, crossing_found,
                crossing_y, crossing_z, output ready);
endinterface

### rtl/wsa_alu.sv
// Shared multiply and saturating add unit with Q16.16 rounding.
module wsa_alu (
  input  wsa_pkg::alu_op_e    op_i,
  input  logic signed [32:0]  opa_i,
  input  logic signed [32:0]  opb_i,
  output logic signed [31:0]  res_o,
  output logic signed [65:0]  prod_o
);
  import wsa_pkg::*;

  logic signed [65:0] rnd;

  assign prod_o = 66'(opa_i) * 66'(opb_i);
  assign rnd    = (prod_o + 66'sd32768) >>> 16;

  always_comb begin
    case (op_i)
      OP_MUL:  res_o = sat32(rnd);
      OP_ADD:  res_o = qas(opa_i[31:0], opb_i[31:0], 1'b0);
      OP_SUB:  res_o = qas(opa_i[31:0], opb_i[31:0], 1'b1);
      default: res_o = '0;
    endcase
  end
endmodule

### rtl/waterline_segment_area_core.sv
// Top level of the waterline segment area block: sequencer, operand store and result register.
//
// One segment word enters on in_i; one result word leaves on out_o for each.
// Configuration registers (waterline sine, cosine, tank mode) are written on
// the plain write port; the user must write them only while the block is
// idle, as the block itself does not enforce it. Index 3 is ignored. An accepted
// word runs through a fixed program on one shared multiplier and saturating
// adder: the curve constants first, then three passes for the area terms at
// t = 1, at the inner crossing and at the outer crossing, then the two width
// cubes, then a final combine. A new word is taken only once the previous one
// has finished and the sequencer is back in idle.
// The result sits in an output register, so the next word may be accepted
// while it waits. If the receiver stalls, the block holds its final step
// until the output register frees up.
// Reset clears the running sums, the crossing latch, the sequencer and the
// output valid flag, and loads sine 0, cosine 1.0 and tank mode 0.
module waterline_segment_area_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i,
  wsa_in_if.sink      in_i,
  wsa_out_if.source   out_o
);
  import wsa_pkg::*;

  state_e state_q;
  logic [4:0] step_q;
  logic [1:0] pass_q;
  logic       cube_idx_q;

  logic signed [17:0] sin_q, cos_q;
  logic               tank_q;

  logic signed [31:0] t1_q, t2_q, dwl_q, a_q, hb_q, c_q, hd_q, yo_q, zo_q;
  logic               in1_q, in2_q;

  logic signed [31:0] t_q, m1_q, m2_q, dy_q, dz_q, wid_q, acc_q, k1_q, k2_q, k3_q;
  logic signed [31:0] y_q, z_q, s_q;
  logic signed [31:0] arf_q, ar1_q, ar2_q, y1_q, z1_q, s1_q, y2_q, z2_q, s2_q;
  logic [57:0]        sq_q, p1_q;
  logic signed [63:0] cb1_q, cb2_q;

  logic signed [31:0] d_q, dw_q;
  logic signed [63:0] dc_q;
  logic               subm_q;

  logic signed [31:0] ws_q, ly_q, lz_q;
  logic signed [63:0] cs_q;
  logic               latched_q;

  logic               out_valid_q;
  logic signed [31:0] o_area_q, o_ws_q, o_ly_q, o_lz_q;
  logic signed [63:0] o_cs_q;
  logic               o_found_q;

  logic               in_acc;
  uop_t               uop;
  alu_op_e            alu_op;
  logic signed [32:0] opa, opb;
  logic signed [31:0] alu_res, va, vb;
  logic signed [65:0] prod;

  logic signed [31:0] cube_src;
  logic [32:0]        av;
  logic               big;
  logic [64:0]        cmag;
  logic signed [63:0] cube_val;

  logic               both, none, commit, do_latch;
  logic signed [31:0] area_n, ws_n, lpy, lpz;
  logic signed [63:0] cs_n;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign uop         = ucode(state_q == ST_PRE, step_q);

  function automatic logic signed [31:0] pick(src_e s, logic signed [31:0] t,
      logic signed [31:0] dwl, logic signed [31:0] a, logic signed [31:0] hb,
      logic signed [31:0] c, logic signed [31:0] hd, logic signed [31:0] yo,
      logic signed [31:0] zo, logic signed [31:0] sn, logic signed [31:0] cs,
      logic signed [31:0] m1, logic signed [31:0] m2, logic signed [31:0] dy,
      logic signed [31:0] dz, logic signed [31:0] wid, logic signed [31:0] acc,
      logic signed [31:0] k1, logic signed [31:0] k2, logic signed [31:0] k3,
      logic signed [31:0] y, logic signed [31:0] z);
    logic signed [31:0] r;
    case (s)
      S_T:     r = t;
      S_DWL:   r = dwl;
      S_A:     r = a;
      S_HB:    r = hb;
      S_C:     r = c;
      S_HD:    r = hd;
      S_YO:    r = yo;
      S_ZO:    r = zo;
      S_SIN:   r = sn;
      S_COS:   r = cs;
      S_HALF:  r = HalfQ;
      S_THIRD: r = ThirdQ;
      S_TWO:   r = TwoQ;
      S_M1:    r = m1;
      S_M2:    r = m2;
      S_DY:    r = dy;
      S_DZ:    r = dz;
      S_WID:   r = wid;
      S_ACC:   r = acc;
      S_K1:    r = k1;
      S_K2:    r = k2;
      S_K3:    r = k3;
      S_Y:     r = y;
      S_Z:     r = z;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign va = pick(uop.src_a, t_q, dwl_q, a_q, hb_q, c_q, hd_q, yo_q, zo_q, 32'(sin_q),
                   32'(cos_q), m1_q, m2_q, dy_q, dz_q, wid_q, acc_q, k1_q, k2_q, k3_q,
                   y_q, z_q);
  assign vb = pick(uop.src_b, t_q, dwl_q, a_q, hb_q, c_q, hd_q, yo_q, zo_q, 32'(sin_q),
                   32'(cos_q), m1_q, m2_q, dy_q, dz_q, wid_q, acc_q, k1_q, k2_q, k3_q,
                   y_q, z_q);

  assign cube_src = cube_idx_q ? s1_q : s2_q;
  assign av       = cube_src[31] ? (33'd0 - 33'(cube_src)) : 33'(cube_src);
  assign big      = |av[32:29];

  always_comb begin
    alu_op = uop.op;
    opa    = 33'(va);
    opb    = 33'(vb);
    if (state_q == ST_CUBE) begin
      alu_op = OP_MUL;
      opb    = {4'd0, av[28:0]};
      case (step_q[1:0])
        2'd0:    opa = {4'd0, av[28:0]};
        2'd1:    opa = {4'd0, sq_q[57:29]};
        default: opa = {4'd0, sq_q[28:0]};
      endcase
    end else if (state_q != ST_PRE && state_q != ST_PASS) begin
      alu_op = OP_NOP;
    end
  end

  wsa_alu u_alu (
    .op_i   (alu_op),
    .opa_i  (opa),
    .opb_i  (opb),
    .res_o  (alu_res),
    .prod_o (prod)
  );

  always_comb begin
    cmag = {2'd0, p1_q, 5'd0} + 65'(({7'd0, sq_q} + 65'd8388608) >> 24);
    if (big || cmag > 65'h0_7fff_ffff_ffff_ffff) begin
      cube_val = cube_src[31] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      cube_val = cube_src[31] ? (64'sd0 - cmag[63:0]) : cmag[63:0];
    end
  end

  always_comb begin
    both   = in1_q && in2_q;
    none   = !in1_q && !in2_q;
    commit = (state_q == ST_FIN2) && (!out_valid_q || out_o.ready);
    if (none) begin
      area_n = (dwl_q > 0) ? arf_q : '0;
      ws_n   = ws_q;
      cs_n   = cs_q;
    end else begin
      area_n = subm_q ? qas(arf_q, d_q, 1'b1) : d_q;
      ws_n   = qas(ws_q, dw_q, subm_q);
      cs_n   = sas64(cs_q, dc_q, subm_q);
    end
    do_latch = !none && (both ? !subm_q : (subm_q ? tank_q : !tank_q));
    if (both ? !tank_q : in1_q) begin
      lpy = y1_q;
      lpz = z1_q;
    end else begin
      lpy = y2_q;
      lpz = z2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q  <= '0;
      cos_q  <= 18'sd65536;
      tank_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIN:  sin_q  <= cfg_data_i;
        CFG_COS:  cos_q  <= cfg_data_i;
        CFG_TANK: tank_q <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pass_q      <= '0;
      cube_idx_q  <= 1'b0;
      ws_q        <= '0;
      cs_q        <= '0;
      latched_q   <= 1'b0;
      ly_q        <= '0;
      lz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !commit) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_PRE;
            step_q  <= '0;
            if (in_i.first_segment) begin
              ws_q      <= '0;
              cs_q      <= '0;
              latched_q <= 1'b0;
              ly_q      <= '0;
              lz_q      <= '0;
            end
          end
        end
        ST_PRE: begin
          if (step_q == 5'(PreLast)) begin
            state_q <= ST_PASS;
            step_q  <= '0;
            pass_q  <= '0;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_PASS: begin
          if (step_q == 5'(PassLast)) begin
            step_q <= '0;
            if (pass_q == 2'd2) begin
              state_q    <= ST_CUBE;
              cube_idx_q <= 1'b0;
            end else begin
              pass_q <= pass_q + 2'd1;
            end
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_CUBE: begin
          if (step_q == 5'(CubeLast)) begin
            step_q <= '0;
            if (cube_idx_q) state_q <= ST_FIN1;
            else cube_idx_q <= 1'b1;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_FIN1: state_q <= ST_FIN2;
        ST_FIN2: begin
          if (commit) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            ws_q        <= ws_n;
            cs_q        <= cs_n;
            if (do_latch && !latched_q) begin
              latched_q <= 1'b1;
              ly_q      <= lpy;
              lz_q      <= lpz;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t1_q  <= in_i.outer_param;
      t2_q  <= in_i.inner_param;
      dwl_q <= in_i.depth_over_inner;
      a_q   <= in_i.coef_y_lin;
      hb_q  <= in_i.coef_y_sq;
      c_q   <= in_i.coef_z_lin;
      hd_q  <= in_i.coef_z_sq;
      yo_q  <= in_i.origin_y;
      zo_q  <= in_i.origin_z;
      in1_q <= (in_i.outer_param > 0) && (in_i.outer_param <= OneQ);
      in2_q <= (in_i.inner_param > 0) && (in_i.inner_param <= OneQ);
      t_q   <= OneQ;
    end
    if (state_q == ST_PRE || state_q == ST_PASS) begin
      case (uop.dst)
        D_M1:    m1_q  <= alu_res;
        D_M2:    m2_q  <= alu_res;
        D_DY:    dy_q  <= alu_res;
        D_DZ:    dz_q  <= alu_res;
        D_WID:   wid_q <= alu_res;
        D_ACC:   acc_q <= alu_res;
        D_K1:    k1_q  <= alu_res;
        D_K2:    k2_q  <= alu_res;
        D_K3:    k3_q  <= alu_res;
        D_Y:     y_q   <= alu_res;
        D_Z:     z_q   <= alu_res;
        D_S:     s_q   <= alu_res;
        default: ;
      endcase
    end
    if (state_q == ST_PASS && step_q == 5'(PassLast)) begin
      case (pass_q)
        2'd0: begin
          arf_q <= acc_q;
          t_q   <= t2_q;
        end
        2'd1: begin
          ar2_q <= acc_q;
          y2_q  <= y_q;
          z2_q  <= z_q;
          s2_q  <= s_q;
          t_q   <= t1_q;
        end
        default: begin
          ar1_q <= acc_q;
          y1_q  <= y_q;
          z1_q  <= z_q;
          s1_q  <= s_q;
        end
      endcase
    end
    if (state_q == ST_CUBE) begin
      case (step_q[1:0])
        2'd0: sq_q <= prod[57:0];
        2'd1: p1_q <= prod[57:0];
        2'd2: sq_q <= prod[57:0];
        default: begin
          if (cube_idx_q) cb1_q <= cube_val;
          else cb2_q <= cube_val;
        end
      endcase
    end
    if (state_q == ST_FIN1) begin
      d_q    <= both ? qas(ar1_q, ar2_q, 1'b1) : (in1_q ? ar1_q : ar2_q);
      dw_q   <= both ? qas(s1_q, s2_q, 1'b1) : (in1_q ? s1_q : s2_q);
      dc_q   <= both ? sas64(cb1_q, cb2_q, 1'b1) : (in1_q ? cb1_q : cb2_q);
      subm_q <= both ? (dwl_q > 0) : (dwl_q < 0);
    end
    if (commit) begin
      o_area_q  <= area_n;
      o_ws_q    <= ws_n;
      o_cs_q    <= cs_n;
      o_found_q <= latched_q || do_latch;
      o_ly_q    <= (do_latch && !latched_q) ? lpy : ly_q;
      o_lz_q    <= (do_latch && !latched_q) ? lpz : lz_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.segment_area   = o_area_q;
  assign out_o.wetted_width   = o_ws_q;
  assign out_o.wetted_cube    = o_cs_q;
  assign out_o.crossing_found = o_found_q;
  assign out_o.crossing_y     = o_ly_q;
  assign out_o.crossing_z     = o_lz_q;

  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN2))
    else $error("result word raised outside the final step");

  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(latched_q) |-> $past(in_acc && in_i.first_segment))
    else $error("crossing latch cleared without a first segment");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (state_q != ST_IDLE || $stable(o_area_q)))
    else $error("stalled result word overwritten");
endmodule
